FILE: src/scft_pkg.sv
// ----------------------------------------------------------------------------
// scft_pkg
// Breakpoint table, segment reciprocals and shared types for the star color
// interpolator.
// ----------------------------------------------------------------------------
package scft_pkg;

	localparam int TABLE_POINTS      = 13;
	localparam int SEG_COUNT         = TABLE_POINTS - 1;
	localparam int SEG_IDX_BITS      = $clog2(TABLE_POINTS);
	localparam int TEMP_BITS_DEFAULT = 16;
	localparam int KELVIN_BITS       = 14;
	localparam int CHAN_BITS         = 8;
	localparam int CHANNELS          = 3;
	// Widest segment is 1400 K, so the offset into a segment fits in 11 bits.
	localparam int DELTA_BITS        = 11;
	// A weighted sum is at most 255 * 1400, which fits in 19 bits.
	localparam int MIX_BITS          = 19;
	// Division by the segment width is a multiply by ceil(2^30 / width). Since
	// every weighted sum times the width stays below 2^30, the floor is exact.
	localparam int RECIP_SHIFT       = 30;
	localparam int RECIP_BITS        = 21;
	localparam int PROD_BITS         = MIX_BITS + RECIP_BITS;

	localparam longint unsigned RECIP_ONE = 64'd1 << RECIP_SHIFT;

	typedef logic [CHAN_BITS-1:0] chan_t;
	typedef chan_t [CHANNELS-1:0] rgb_t;   // [2] red, [1] green, [0] blue
	typedef logic [SEG_IDX_BITS-1:0] seg_idx_t;
	typedef logic [DELTA_BITS-1:0] delta_t;
	typedef logic [MIX_BITS-1:0] mix_t;
	typedef logic [RECIP_BITS-1:0] recip_t;

	localparam int CH_RED   = 2;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 0;

	localparam logic [KELVIN_BITS-1:0] BREAK_KELVIN [TABLE_POINTS] = '{
		14'd1600, 14'd3000, 14'd3700, 14'd4500, 14'd5500, 14'd6500, 14'd7200,
		14'd8000, 14'd9000, 14'd10000, 14'd11000, 14'd12000, 14'd13000
	};

	localparam rgb_t BREAK_COLOR [TABLE_POINTS] = '{
		{8'd255, 8'd118, 8'd0},
		{8'd255, 8'd162, 8'd60},
		{8'd255, 8'd180, 8'd107},
		{8'd255, 8'd206, 8'd146},
		{8'd255, 8'd219, 8'd186},
		{8'd255, 8'd238, 8'd222},
		{8'd255, 8'd249, 8'd251},
		{8'd240, 8'd241, 8'd255},
		{8'd227, 8'd233, 8'd255},
		{8'd214, 8'd225, 8'd255},
		{8'd207, 8'd218, 8'd255},
		{8'd200, 8'd213, 8'd255},
		{8'd191, 8'd211, 8'd255}
	};

	localparam delta_t SEG_RANGE [SEG_COUNT] = '{
		11'd1400, 11'd700, 11'd800, 11'd1000, 11'd1000, 11'd700,
		11'd800, 11'd1000, 11'd1000, 11'd1000, 11'd1000, 11'd1000
	};

	localparam recip_t SEG_RECIP [SEG_COUNT] = '{
		RECIP_BITS'((RECIP_ONE + 64'd1399) / 64'd1400),
		RECIP_BITS'((RECIP_ONE + 64'd699) / 64'd700),
		RECIP_BITS'((RECIP_ONE + 64'd799) / 64'd800),
		RECIP_BITS'((RECIP_ONE + 64'd999) / 64'd1000),
		RECIP_BITS'((RECIP_ONE + 64'd999) / 64'd1000),
		RECIP_BITS'((RECIP_ONE + 64'd699) / 64'd700),
		RECIP_BITS'((RECIP_ONE + 64'd799) / 64'd800),
		RECIP_BITS'((RECIP_ONE + 64'd999) / 64'd1000),
		RECIP_BITS'((RECIP_ONE + 64'd999) / 64'd1000),
		RECIP_BITS'((RECIP_ONE + 64'd999) / 64'd1000),
		RECIP_BITS'((RECIP_ONE + 64'd999) / 64'd1000),
		RECIP_BITS'((RECIP_ONE + 64'd999) / 64'd1000)
	};

endpackage

FILE: src/star_color_from_temperature_core.sv
// ----------------------------------------------------------------------------
// star_color_from_temperature_core
// Maps a temperature in kelvin to an RGB color by linear interpolation over a
// fixed table of breakpoints from 1600 K to 13000 K.
// ----------------------------------------------------------------------------
// The core takes one temperature per cycle while the output is not stalled
// and returns its color through a three stage pipeline: segment search,
// weighted sum of the two neighboring colors, and division by the segment
// width done as a multiply by a stored reciprocal. That multiply sets the
// length of the last stage. Temperatures at or below 1600 K give the first
// color, those at or above 13000 K the last. A stalled output holds only the
// stages behind it that are full, so empty stages keep filling.
module star_color_from_temperature_core
	import scft_pkg::*;
#(
	parameter int TEMP_BITS = TEMP_BITS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 temperature_valid,
	output logic                 temperature_ready,
	input  logic [TEMP_BITS-1:0] temperature_kelvin,
	output logic                 color_valid,
	input  logic                 color_ready,
	output logic [CHAN_BITS-1:0] red,
	output logic [CHAN_BITS-1:0] green,
	output logic [CHAN_BITS-1:0] blue
);

	logic en_s1, en_s2, en_s3;

	// Stage 1: segment search.
	seg_idx_t seg_idx;
	logic     below_first, above_last;

	logic     valid_s1;
	seg_idx_t idx_s1;
	logic     lo_clamp_s1, hi_clamp_s1;
	delta_t   temp_low_s1;

	// Stage 2: weighted sums.
	delta_t seg_delta, seg_range;
	rgb_t   color_lo, color_hi;
	mix_t   mix_next [CHANNELS];

	logic   valid_s2;
	mix_t   mix_s2 [CHANNELS];
	recip_t recip_s2;

	// Stage 3: reciprocal multiply.
	logic [PROD_BITS-1:0] prod [CHANNELS];
	logic                 valid_s3;
	rgb_t                 color_s3;

	assign en_s3 = !valid_s3 || color_ready;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign temperature_ready = en_s1;

	// The last breakpoint strictly below the temperature opens the segment.
	// Clamped temperatures fall into the first or last segment and get an
	// offset of zero or the full width, which yields the end color exactly.
	always_comb begin
		seg_idx = '0;
		for (int i = 1; i < SEG_COUNT; i++) begin
			if (temperature_kelvin > TEMP_BITS'(BREAK_KELVIN[i]))
				seg_idx = SEG_IDX_BITS'(i);
		end
		below_first = !(temperature_kelvin > TEMP_BITS'(BREAK_KELVIN[0]));
		above_last  = temperature_kelvin >= TEMP_BITS'(BREAK_KELVIN[TABLE_POINTS-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en_s1)
			valid_s1 <= temperature_valid;
	end

	always_ff @(posedge clk) begin
		if (en_s1 && temperature_valid) begin
			idx_s1      <= seg_idx;
			lo_clamp_s1 <= below_first;
			hi_clamp_s1 <= above_last;
			temp_low_s1 <= temperature_kelvin[DELTA_BITS-1:0];
		end
	end

	// Inside a segment the offset is below 2^11, so the low bits suffice.
	always_comb begin
		seg_range = SEG_RANGE[idx_s1];
		color_lo  = BREAK_COLOR[idx_s1];
		color_hi  = BREAK_COLOR[SEG_IDX_BITS'(idx_s1 + 1'b1)];
		if (lo_clamp_s1)
			seg_delta = '0;
		else if (hi_clamp_s1)
			seg_delta = seg_range;
		else
			seg_delta = temp_low_s1 - BREAK_KELVIN[idx_s1][DELTA_BITS-1:0];
		for (int c = 0; c < CHANNELS; c++) begin
			mix_next[c] = MIX_BITS'(color_lo[c]) * MIX_BITS'(seg_range - seg_delta)
				+ MIX_BITS'(color_hi[c]) * MIX_BITS'(seg_delta);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (en_s2)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			mix_s2   <= mix_next;
			recip_s2 <= SEG_RECIP[idx_s1];
		end
	end

	always_comb begin
		for (int c = 0; c < CHANNELS; c++)
			prod[c] = PROD_BITS'(mix_s2[c]) * PROD_BITS'(recip_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (en_s3)
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			for (int c = 0; c < CHANNELS; c++)
				color_s3[c] <= prod[c][RECIP_SHIFT +: CHAN_BITS];
		end
	end

	assign color_valid = valid_s3;
	assign red         = color_s3[CH_RED];
	assign green       = color_s3[CH_GREEN];
	assign blue        = color_s3[CH_BLUE];

	// A held result must not change under a stall.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !color_ready |=> valid_s3 && $stable(color_s3))
		else $error("result changed while stalled");

	// An accepted temperature always lands in the first stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		temperature_valid && temperature_ready |=> valid_s1)
		else $error("accepted temperature lost");

	// The segment index always names a real segment.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> idx_s1 < SEG_IDX_BITS'(SEG_COUNT))
		else $error("segment index out of range");

	// The offset never exceeds the width of its segment.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> seg_delta <= seg_range)
		else $error("segment offset exceeds segment width");

endmodule
